### sv/jptc_pkg.sv
package jptc_pkg;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned TARGET_W  = 11;
  localparam int unsigned VERDICT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADVANCE = 2'd0,
    KIND_JUMP    = 2'd1,
    KIND_COND    = 2'd2
  } kind_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NEVER     = 2'd0,
    VERDICT_SOMETIMES = 2'd1,
    VERDICT_ALWAYS    = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    MARK_WHITE = 2'd0,
    MARK_GREY  = 2'd1,
    MARK_BLACK = 2'd2
  } mark_e;

  // which successor of the top node is examined next
  typedef enum logic [1:0] {
    PH_NEXT = 2'd0,
    PH_JUMP = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_MARK,
    ST_STEP,
    ST_POP,
    ST_DONE
  } state_e;

endpackage

### sv/jptc_intf.sv
interface jptc_req_if;
  logic                          valid;
  logic                          ready;
  logic [jptc_pkg::KIND_W-1:0]   instr_kind;
  logic [jptc_pkg::TARGET_W-1:0] jump_target;
  logic                          last_instr;

  modport source (output valid, output instr_kind, output jump_target, output last_instr,
                  input ready);
  modport sink (input valid, input instr_kind, input jump_target, input last_instr,
                output ready);
endinterface

interface jptc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [jptc_pkg::VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

### sv/jptc_ram.sv
module jptc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/jump_program_termination_classifier_core.sv
// Jump program termination classifier.
// req_i carries one instruction per request (kind, 1-based jump target, last flag).
// Each accepted instruction within MAX_INSTR is written to the edge memory, so a
// program loads at one instruction per clock. The request with last_instr set
// closes the program and starts a depth-first walk from instruction 0; req_i is
// held off until the walk ends. Every step of the walk waits on the registered
// read of the mark, edge or stack memory that it needs.
// rsp_o then carries one verdict (never, sometimes, always reaches the end) from
// an output register, and req_i opens for the next program in the same cycle.
// If the receiver stalls, the verdict holds and the next program still loads;
// its walk waits at the end until the earlier verdict has been taken.
// Instructions beyond MAX_INSTR are dropped. Reset is asynchronous and returns
// the block to loading an empty program; the memories need no clearing pass,
// since marks are rewritten white as each instruction loads.
module jump_program_termination_classifier_core #(
  parameter int unsigned MAX_INSTR = 1024
) (
  input logic          clk_i,
  input logic          rst_ni,
  jptc_req_if.sink     req_i,
  jptc_rsp_if.source   rsp_o
);

  localparam int unsigned AW  = $clog2(MAX_INSTR);
  localparam int unsigned LW  = $clog2(MAX_INSTR + 1);
  localparam int unsigned TW  = jptc_pkg::TARGET_W;
  localparam int unsigned CW  = (LW > TW) ? LW : TW;
  localparam int unsigned EW  = TW + 2;
  localparam int unsigned SW  = AW + 2;

  jptc_pkg::state_e state_q, state_d;
  logic [LW-1:0]    len_q, len_d;
  logic [LW-1:0]    depth_q, depth_d;
  logic [AW-1:0]    top_node_q, top_node_d;
  jptc_pkg::phase_e top_ph_q, top_ph_d;
  logic [AW-1:0]    w_q, w_d;
  logic             end_q, end_d;
  logic             cyc_q, cyc_d;
  logic             out_valid_q, out_valid_d;
  jptc_pkg::verdict_e verdict_q, verdict_d;

  // memory ports
  logic          edge_we, edge_re;
  logic [AW-1:0] edge_addr;
  logic [EW-1:0] edge_wdata, edge_rdata;
  logic          mark_we, mark_re;
  logic [AW-1:0] mark_addr;
  logic [1:0]    mark_wdata, mark_rdata;
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_addr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  // decode
  logic             load_req;
  logic             len_room;
  logic             e_has_next, e_has_jump;
  logic [TW-1:0]    e_jump_node;
  logic             take;
  logic [CW-1:0]    cand;
  logic             cand_end, cand_live;
  jptc_pkg::mark_e  mark_rd;
  logic             out_free;
  logic [TW-1:0]    tgt_m1;

  assign req_i.ready = (state_q == jptc_pkg::ST_LOAD);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.verdict = verdict_q;

  assign load_req = req_i.valid && (state_q == jptc_pkg::ST_LOAD);
  assign len_room = (len_q < LW'(MAX_INSTR));
  assign out_free = !out_valid_q || rsp_o.ready;
  assign tgt_m1   = req_i.jump_target - TW'(1);

  assign {e_has_next, e_has_jump, e_jump_node} = edge_rdata;
  assign mark_rd = jptc_pkg::mark_e'(mark_rdata);

  always_comb begin
    take = 1'b0;
    cand = CW'(top_node_q) + CW'(1);
    case (top_ph_q)
      jptc_pkg::PH_NEXT: begin
        take = e_has_next;
        cand = CW'(top_node_q) + CW'(1);
      end
      jptc_pkg::PH_JUMP: begin
        take = e_has_jump;
        cand = CW'(e_jump_node);
      end
      default: begin
        take = 1'b0;
      end
    endcase
    cand_end  = take && (cand == CW'(len_q));
    cand_live = take && (cand < CW'(len_q));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jptc_pkg::ST_LOAD: begin
        if (req_i.valid && req_i.last_instr) begin
          state_d = jptc_pkg::ST_START;
        end
      end
      jptc_pkg::ST_START: begin
        state_d = jptc_pkg::ST_MARK;
      end
      jptc_pkg::ST_MARK: begin
        state_d = jptc_pkg::ST_STEP;
      end
      jptc_pkg::ST_STEP: begin
        if (top_ph_q == jptc_pkg::PH_DONE) begin
          state_d = (depth_q == LW'(1)) ? jptc_pkg::ST_DONE : jptc_pkg::ST_POP;
        end else if (cand_live) begin
          state_d = jptc_pkg::ST_MARK;
        end
      end
      jptc_pkg::ST_POP: begin
        state_d = jptc_pkg::ST_STEP;
      end
      jptc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = jptc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = jptc_pkg::ST_LOAD;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    len_d       = len_q;
    depth_d     = depth_q;
    top_node_d  = top_node_q;
    top_ph_d    = top_ph_q;
    w_d         = w_q;
    end_d       = end_q;
    cyc_d       = cyc_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    verdict_d   = verdict_q;

    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_addr  = len_q[AW-1:0];
    edge_wdata = {req_i.instr_kind != jptc_pkg::KIND_JUMP,
                  (req_i.instr_kind != jptc_pkg::KIND_ADVANCE) && (req_i.jump_target != '0),
                  (req_i.jump_target != '0) ? tgt_m1 : TW'(0)};
    mark_we    = 1'b0;
    mark_re    = 1'b0;
    mark_addr  = len_q[AW-1:0];
    mark_wdata = jptc_pkg::MARK_WHITE;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_addr   = AW'(depth_q - LW'(1));
    stk_wdata  = {top_node_q, top_ph_q};

    case (state_q)
      jptc_pkg::ST_LOAD: begin
        if (load_req && len_room) begin
          edge_we = 1'b1;
          mark_we = 1'b1;
          len_d   = len_q + LW'(1);
        end
      end
      jptc_pkg::ST_START: begin
        // program holds at least one instruction, so node 0 is live
        mark_re   = 1'b1;
        mark_addr = '0;
        w_d       = '0;
      end
      jptc_pkg::ST_MARK: begin
        case (mark_rd)
          jptc_pkg::MARK_WHITE: begin
            mark_we    = 1'b1;
            mark_addr  = w_q;
            mark_wdata = jptc_pkg::MARK_GREY;
            // spill the old top below the new one
            stk_we     = (depth_q != '0);
            edge_re    = 1'b1;
            edge_addr  = w_q;
            top_node_d = w_q;
            top_ph_d   = jptc_pkg::PH_NEXT;
            depth_d    = depth_q + LW'(1);
          end
          jptc_pkg::MARK_GREY: begin
            cyc_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      jptc_pkg::ST_STEP: begin
        case (top_ph_q)
          jptc_pkg::PH_NEXT: top_ph_d = jptc_pkg::PH_JUMP;
          jptc_pkg::PH_JUMP: top_ph_d = jptc_pkg::PH_DONE;
          default: begin
            mark_we    = 1'b1;
            mark_addr  = top_node_q;
            mark_wdata = jptc_pkg::MARK_BLACK;
            depth_d    = depth_q - LW'(1);
            stk_re     = (depth_q != LW'(1));
            stk_addr   = AW'(depth_q - LW'(2));
          end
        endcase
        if (cand_end) begin
          end_d = 1'b1;
        end
        if (cand_live) begin
          mark_re   = 1'b1;
          mark_addr = cand[AW-1:0];
          w_d       = cand[AW-1:0];
        end
      end
      jptc_pkg::ST_POP: begin
        top_node_d = stk_rdata[SW-1:2];
        top_ph_d   = jptc_pkg::phase_e'(stk_rdata[1:0]);
        edge_re    = 1'b1;
        edge_addr  = stk_rdata[SW-1:2];
      end
      jptc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (!end_q) begin
            verdict_d = jptc_pkg::VERDICT_NEVER;
          end else if (cyc_q) begin
            verdict_d = jptc_pkg::VERDICT_SOMETIMES;
          end else begin
            verdict_d = jptc_pkg::VERDICT_ALWAYS;
          end
          len_d   = '0;
          end_d   = 1'b0;
          cyc_d   = 1'b0;
          depth_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jptc_pkg::ST_LOAD;
      len_q       <= '0;
      depth_q     <= '0;
      end_q       <= 1'b0;
      cyc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      depth_q     <= depth_d;
      end_q       <= end_d;
      cyc_q       <= cyc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_node_q <= top_node_d;
    top_ph_q   <= top_ph_d;
    w_q        <= w_d;
    verdict_q  <= verdict_d;
  end

  jptc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_INSTR)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .re_i    (edge_re),
    .addr_i  (edge_addr),
    .wdata_i (edge_wdata),
    .rdata_o (edge_rdata)
  );

  jptc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_INSTR)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .re_i    (mark_re),
    .addr_i  (mark_addr),
    .wdata_i (mark_wdata),
    .rdata_o (mark_rdata)
  );

  jptc_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_INSTR)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .re_i    (stk_re),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

endmodule

### sv/jptc_checker.sv
module jptc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           req_last_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [jptc_pkg::VERDICT_W-1:0] rsp_verdict_i
);

  // no result survives reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !rsp_valid_i)
    else $error("result valid during reset");

  // a stalled result is not withdrawn
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // closing a program starts the walk, which holds off further requests
  a_walk_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_last_i |=> !req_ready_i)
    else $error("request taken right after the last instruction");

  // loading continues back to back until the last instruction
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !req_last_i |=> req_ready_i)
    else $error("loading stalled mid program");

  a_verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_verdict_i == jptc_pkg::VERDICT_NEVER) ||
                    (rsp_verdict_i == jptc_pkg::VERDICT_SOMETIMES) ||
                    (rsp_verdict_i == jptc_pkg::VERDICT_ALWAYS))
    else $error("illegal verdict code");

endmodule

bind jump_program_termination_classifier_core jptc_checker u_jptc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_last_i    (req_i.last_instr),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_verdict_i (rsp_o.verdict)
);

### tb/jump_program_termination_classifier_core_tb.sv
module jump_program_termination_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jptc_pkg::*;

  localparam int unsigned PROG_DEPTH  = 1024;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 190;

  // kind code 3 is not in the enum; the block treats it as a conditional jump
  localparam logic [KIND_W-1:0]   KIND_SPARE  = 2'd3;
  localparam logic [TARGET_W-1:0] TARGET_NONE = '0;
  localparam logic [TARGET_W-1:0] TARGET_TOP  = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jptc_req_if req_if ();
  jptc_rsp_if rsp_if ();

  jump_program_termination_classifier_core #(
    .MAX_INSTR (PROG_DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // program image as seen by the block, rebuilt per program
  bit          next_edge [PROG_DEPTH];
  bit          jump_edge [PROG_DEPTH];
  int unsigned jump_dest [PROG_DEPTH];
  int unsigned loaded_len = 0;

  verdict_e    expected_verdicts [$];
  int unsigned mismatches       = 0;
  int unsigned cycle_count      = 0;
  int unsigned instr_accepted   = 0;
  int unsigned verdict_tally [3] = '{default: 0};

  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned hold_requests = 0;

  // Depth-first walk from node 0 over the loaded program. A node index equal to
  // the length is the end; anything above it is a dropped edge.
  function automatic verdict_e classify_program();
    mark_e       mark      [PROG_DEPTH];
    int unsigned walk_node [PROG_DEPTH];
    phase_e      walk_ph   [PROG_DEPTH];
    int unsigned top;
    int unsigned v;
    int unsigned w;
    bit          pending;
    bit          reached;
    bit          looped;
    foreach (mark[i]) mark[i] = MARK_WHITE;
    top     = 0;
    reached = 1'b0;
    looped  = 1'b0;
    w       = 0;
    pending = 1'b1;
    while (pending || top != 0) begin
      if (pending) begin
        pending = 1'b0;
        if (w == loaded_len) begin
          reached = 1'b1;
        end else if (w < loaded_len) begin
          if (mark[w] == MARK_WHITE) begin
            mark[w]        = MARK_GREY;
            walk_node[top] = w;
            walk_ph[top]   = PH_NEXT;
            top++;
          end else if (mark[w] == MARK_GREY) begin
            looped = 1'b1;
          end
        end
      end else begin
        v = walk_node[top-1];
        case (walk_ph[top-1])
          PH_NEXT: begin
            walk_ph[top-1] = PH_JUMP;
            if (next_edge[v]) begin
              w       = v + 1;
              pending = 1'b1;
            end
          end
          PH_JUMP: begin
            walk_ph[top-1] = PH_DONE;
            if (jump_edge[v]) begin
              w       = jump_dest[v];
              pending = 1'b1;
            end
          end
          default: begin
            mark[v] = MARK_BLACK;
            top--;
          end
        endcase
      end
    end
    if (!reached) return VERDICT_NEVER;
    if (looped) return VERDICT_SOMETIMES;
    return VERDICT_ALWAYS;
  endfunction

  function automatic void load_instruction(logic [KIND_W-1:0] kind,
                                           logic [TARGET_W-1:0] target, logic last);
    if (loaded_len < PROG_DEPTH) begin
      next_edge[loaded_len] = (kind != KIND_JUMP);
      jump_edge[loaded_len] = (kind != KIND_ADVANCE) && (target != TARGET_NONE);
      jump_dest[loaded_len] = (target != TARGET_NONE) ? int'(target) - 1 : 0;
      loaded_len++;
    end
    if (last) begin
      expected_verdicts.push_back(classify_program());
      loaded_len = 0;
    end
  endfunction

  // accepted requests feed the predictor, accepted verdicts are checked
  always @(posedge clk_i) begin : check_verdicts
    verdict_e want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: verdict %0d with no program outstanding", $time, rsp_if.verdict);
        end else begin
          want = expected_verdicts.pop_front();
          verdict_tally[want]++;
          if (rsp_if.verdict !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: verdict mismatch, expected %0d (%s), got %0d", $time, want,
                       want.name(), rsp_if.verdict);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        instr_accepted++;
        load_instruction(req_if.instr_kind, req_if.jump_target, req_if.last_instr);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d verdicts outstanding", cycle_count,
               expected_verdicts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin : drive_ready
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served  = 0;
    hold_left     = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  // entered and left at a falling edge; valid stays high so the next request
  // can follow back to back
  task automatic send_instr(logic [KIND_W-1:0] kind, logic [TARGET_W-1:0] target, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.instr_kind  = kind;
    req_if.jump_target = target;
    req_if.last_instr  = last;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // short programs, mostly with targets inside the program so the walk gets
  // somewhere; some targets past the end, zero, or with the top bit set
  task automatic send_random_program(output int unsigned sent);
    int unsigned         len;
    int unsigned         pick;
    logic [KIND_W-1:0]   kind;
    logic [TARGET_W-1:0] target;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      kind = KIND_ADVANCE;
      else if (pick < 6) kind = KIND_JUMP;
      else if (pick < 9) kind = KIND_COND;
      else               kind = KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 80)      target = TARGET_W'($urandom_range(1, len + 1));
      else if (pick < 88) target = TARGET_W'($urandom_range(len + 2, len + 20));
      else if (pick < 94) target = TARGET_NONE;
      else                target = TARGET_W'($urandom_range(PROG_DEPTH, TARGET_TOP));
      send_instr(kind, target, i == len - 1);
    end
    sent = len;
  endtask

  task automatic test_special_cases();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    send_instr(KIND_ADVANCE, TARGET_TOP, 1'b1);   // straight to the end
    send_instr(KIND_JUMP, 11'd1, 1'b1);           // self loop only
    send_instr(KIND_COND, 11'd1, 1'b1);           // self loop or end
    send_instr(KIND_SPARE, 11'd1, 1'b1);
    send_instr(KIND_JUMP, TARGET_NONE, 1'b1);     // no edges at all
    // jump past the end is dropped
    send_instr(KIND_JUMP, 11'd5, 1'b0);
    send_instr(KIND_ADVANCE, TARGET_NONE, 1'b1);
    // jump to exactly the end node
    send_instr(KIND_JUMP, 11'd3, 1'b0);
    send_instr(KIND_ADVANCE, TARGET_NONE, 1'b1);
    // conditional kinds without a target keep only the fall-through
    send_instr(KIND_COND, TARGET_NONE, 1'b0);
    send_instr(KIND_SPARE, TARGET_NONE, 1'b1);
    // edge into an already finished node is not a cycle
    send_instr(KIND_COND, 11'd3, 1'b0);
    send_instr(KIND_ADVANCE, TARGET_NONE, 1'b0);
    send_instr(KIND_ADVANCE, TARGET_NONE, 1'b1);
    // loop that the walk never reaches
    send_instr(KIND_JUMP, 11'd3, 1'b0);
    send_instr(KIND_JUMP, 11'd2, 1'b0);
    send_instr(KIND_ADVANCE, TARGET_NONE, 1'b1);
    send_instr(KIND_COND, TARGET_TOP, 1'b1);
    send_instr(KIND_JUMP, 11'd1024, 1'b1);
    wait_idle();
  endtask

  // exactly full program, random edges, the end node reachable by jump
  task automatic test_longest_program();
    logic [KIND_W-1:0] kind;
    for (int unsigned i = 0; i < PROG_DEPTH; i++) begin
      kind = KIND_W'($urandom_range(0, 3));
      send_instr(kind, TARGET_W'($urandom_range(1, PROG_DEPTH + 1)), i == PROG_DEPTH - 1);
    end
    wait_idle();
  endtask

  // instructions past the limit are dropped, the last one still closes the program
  task automatic test_overflow();
    for (int unsigned i = 0; i < PROG_DEPTH + 6; i++) begin
      if (i < PROG_DEPTH - 1)
        send_instr(KIND_ADVANCE, TARGET_W'($urandom_range(0, TARGET_TOP)), 1'b0);
      else if (i == PROG_DEPTH - 1)
        send_instr(KIND_JUMP, TARGET_W'(PROG_DEPTH + 1), 1'b0);
      else
        send_instr(KIND_JUMP, 11'd1, i == PROG_DEPTH + 5);
    end
    wait_idle();
  endtask

  // verdict held back long enough that the next walk waits and requests back up
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_requests++;
    for (int unsigned p = 0; p < 4; p++) begin
      send_instr(KIND_COND, TARGET_W'(p + 1), 1'b0);
      send_instr(KIND_ADVANCE, TARGET_NONE, 1'b0);
      send_instr(KIND_JUMP, 11'd4, 1'b1);
    end
    wait_idle();
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned items;
    int unsigned sent;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    items = 0;
    while (items < PHASE_ITEMS) begin
      send_random_program(sent);
      items += sent;
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0);
    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(36, 36);
    wait_idle();
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.instr_kind  = KIND_ADVANCE;
    req_if.jump_target = TARGET_NONE;
    req_if.last_instr  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_special_cases();
    test_longest_program();
    test_overflow();
    test_output_hold_off();
    test_random_traffic();

    $display("Checked %0d verdicts from %0d instructions: %0d never, %0d sometimes, %0d always",
             verdict_tally[VERDICT_NEVER] + verdict_tally[VERDICT_SOMETIMES] +
             verdict_tally[VERDICT_ALWAYS], instr_accepted, verdict_tally[VERDICT_NEVER],
             verdict_tally[VERDICT_SOMETIMES], verdict_tally[VERDICT_ALWAYS]);
    $display("Edge cases, full and overlong programs, output hold-off, four idle mixes");
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d verdicts missing", mismatches, expected_verdicts.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
